@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btu assertion failed");

// next-cycle implication, disabled in reset
`define BTU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btu assertion failed");

`endif

@@ sv/btu_pkg.sv @@
// ----------------------------------------------------------------------------
// Busy-time utilization monitor package
// Shared types, codes and constants of the monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btu_pkg;

    localparam int KIND_W   = 2;
    localparam int US_W     = 32;
    localparam int MS_W     = 48;
    localparam int WIN_W    = 11;
    localparam int PCT_W    = 7;
    localparam int QBITS    = 7;
    localparam int NUM_W    = US_W + PCT_W;
    localparam int WUS_W    = 21;
    localparam int DSH_W    = WUS_W + QBITS;
    localparam int CNT_W    = 3;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [WIN_W-1:0] WIN_MIN   = 11'd100;
    localparam logic [WIN_W-1:0] WIN_MAX   = 11'd2000;
    localparam logic [WIN_W-1:0] WIN_RESET = 11'd1000;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [CNT_W-1:0] LAST_STEP = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_LOAD,
        ST_DIV_CHECK,
        ST_DIV_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_load;
        logic div_check;
        logic div_step;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic close_need;
        logic out_free;
    } stat_t;

endpackage

@@ sv/btu_item_if.sv @@
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one input event beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface btu_item_if import btu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [US_W-1:0]   now_us;
    logic [MS_W-1:0]   now_ms;

    modport source (output valid, kind, now_us, now_ms, input ready);
    modport sink   (input valid, kind, now_us, now_ms, output ready);
endinterface

@@ sv/btu_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface btu_result_if import btu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] cpu_percent;
    logic             window_closed;

    modport source (output valid, cpu_percent, window_closed, input ready);
    modport sink   (input valid, cpu_percent, window_closed, output ready);
endinterface

@@ sv/btu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Monitor controller
// Sequences capture, update, the serial percent divide and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btu_ctrl
    import btu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.close_need)
                    state_next = ST_DIV_LOAD;
                else if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_DIV_LOAD:
                state_next = ST_DIV_CHECK;
            ST_DIV_CHECK:
            begin
                state_next = ST_DIV_STEP;
                cnt_next   = LAST_STEP;
            end
            ST_DIV_STEP:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_EXEC:
            begin
                if (!stat.close_need && stat.out_free)
                begin
                    cmd.exec     = 1'b1;
                    cmd.out_load = 1'b1;
                end
            end
            ST_DIV_LOAD:
                cmd.div_load = 1'b1;
            ST_DIV_CHECK:
                cmd.div_check = 1'b1;
            ST_DIV_STEP:
                cmd.div_step = 1'b1;
            ST_FINISH:
            begin
                cmd.commit   = stat.out_free;
                cmd.out_load = stat.out_free;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

@@ sv/btu_datapath.sv @@
// ----------------------------------------------------------------------------
// Monitor datapath
// Task timing, busy accumulation, window tracking, restoring divider and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btu_datapath
    import btu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [WIN_W-1:0]  cfg_wr_data,
    input  logic [KIND_W-1:0] kind,
    input  logic [US_W-1:0]   now_us,
    input  logic [MS_W-1:0]   now_ms,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PCT_W-1:0]  out_percent,
    output logic              out_closed
);

    logic [WIN_W-1:0]  window_ms_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [US_W-1:0]   now_us_reg;
    logic [MS_W-1:0]   now_ms_reg;
    logic [US_W-1:0]   task_start_reg;
    logic              task_active_reg;
    logic [US_W-1:0]   busy_reg, busy_next;
    logic [MS_W-1:0]   win_start_reg;
    logic [PCT_W-1:0]  last_pct_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QBITS-1:0]  quo_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    logic [PCT_W-1:0]  out_pct_reg;
    logic              out_closed_reg;

    logic [WIN_W-1:0]  cfg_clamped;
    logic [US_W-1:0]   task_elapsed;
    logic [US_W:0]     busy_sum;
    logic [MS_W-1:0]   win_elapsed;
    logic [NUM_W-1:0]  num_init;
    logic [WUS_W-1:0]  win_us;
    logic [NUM_W-1:0]  dsh_ext;
    logic              rem_ge;
    logic [PCT_W-1:0]  pct_new;

    assign cfg_clamped = (cfg_wr_data < WIN_MIN) ? WIN_MIN :
                         (cfg_wr_data > WIN_MAX) ? WIN_MAX : cfg_wr_data;

    assign task_elapsed = now_us_reg - task_start_reg;
    assign busy_sum     = {1'b0, busy_reg} + {1'b0, task_elapsed};
    assign win_elapsed  = now_ms_reg - win_start_reg;

    assign num_init = (NUM_W'(busy_reg) << 6) + (NUM_W'(busy_reg) << 5)
                    + (NUM_W'(busy_reg) << 2);
    assign win_us   = WUS_W'(window_ms_reg) * WUS_W'(1000);
    assign dsh_ext  = NUM_W'(dsh_reg);
    assign rem_ge   = rem_reg >= dsh_ext;
    assign pct_new  = (sat_reg || quo_reg > PCT_MAX) ? PCT_MAX : quo_reg;

    assign stat.close_need = (kind_reg == KIND_TICK) && (win_start_reg != '0)
                           && (win_elapsed >= MS_W'(window_ms_reg));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.exec && kind_reg == KIND_END && task_active_reg)
            busy_next = busy_sum[US_W] ? '1 : busy_sum[US_W-1:0];
        else if (cmd.commit)
            busy_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg   <= WIN_RESET;
            task_start_reg  <= '0;
            task_active_reg <= 1'b0;
            busy_reg        <= '0;
            win_start_reg   <= '0;
            last_pct_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                window_ms_reg <= cfg_clamped;
            busy_reg <= busy_next;
            if (cmd.exec)
            begin
                case (kind_reg)
                    KIND_START:
                    begin
                        if (!task_active_reg)
                        begin
                            task_start_reg  <= now_us_reg;
                            task_active_reg <= 1'b1;
                        end
                    end
                    KIND_END:
                        task_active_reg <= 1'b0;
                    KIND_TICK:
                    begin
                        if (win_start_reg == '0)
                            win_start_reg <= now_ms_reg;
                    end
                    default:
                        task_active_reg <= task_active_reg;
                endcase
            end
            if (cmd.commit)
            begin
                last_pct_reg  <= pct_new;
                win_start_reg <= now_ms_reg;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold captured item, divider operands and output data
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            now_us_reg <= now_us;
            now_ms_reg <= now_ms;
        end
        if (cmd.div_load)
        begin
            rem_reg <= num_init;
            dsh_reg <= DSH_W'(win_us) << QBITS;
            quo_reg <= '0;
        end
        if (cmd.div_check)
        begin
            sat_reg <= rem_ge;
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - dsh_ext;
            quo_reg <= {quo_reg[QBITS-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.out_load)
        begin
            out_pct_reg    <= cmd.commit ? pct_new : last_pct_reg;
            out_closed_reg <= cmd.commit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_percent = out_pct_reg;
    assign out_closed  = out_closed_reg;

endmodule

@@ sv/busy_time_utilization_monitor.sv @@
// Each item beat is captured, then executed and its result loaded; a tick that
// closes a window first runs the 7-step restoring divider. No new item is
// accepted until the previous one is finished, a stalled result channel holds
// it, and the single shared divider serves every close.
// Reset: async active low; clears FSM and busy state, window_ms back to 1000.
// ----------------------------------------------------------------------------
// Busy-time utilization monitor
// Times task activity and reports the busy percentage of each window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module busy_time_utilization_monitor
    import btu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data,
    btu_item_if.sink         item,
    btu_result_if.source     result
);

    cmd_t  cmd;
    stat_t stat;

    btu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    btu_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (item.kind),
        .now_us      (item.now_us),
        .now_ms      (item.now_ms),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_percent (result.cpu_percent),
        .out_closed  (result.window_closed)
    );

endmodule

@@ sv/btu_checker.sv @@
// ----------------------------------------------------------------------------
// Monitor port checker
// Port-level assertions, bound to the monitor top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btu_checker
    import btu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PCT_W-1:0] out_percent,
    input logic             out_closed
);

    `BTU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `BTU_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_percent) && $stable(out_closed))
    `BTU_ASSERT_IMP(a_pct_range, clk, rst_n, out_valid, out_percent <= PCT_MAX)
    `BTU_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind busy_time_utilization_monitor btu_checker u_btu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_percent (result.cpu_percent),
    .out_closed  (result.window_closed)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Busy-time utilization monitor testbench
// Drives task-start, task-end, tick and unused-kind beats through the item
// channel. A scoreboard predicts each result beat from its own copy of the
// monitor state and checks it field by field. Phases change the window length
// and the idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import btu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_ITEMS = 62;

    class utilization_scoreboard;
        typedef struct packed {
            logic [PCT_W-1:0] cpu_percent;
            logic             window_closed;
        } reading_t;

        logic [WIN_W-1:0] win_ms;
        logic [US_W-1:0]  start_us;
        logic             timing;
        logic [US_W-1:0]  busy_us;
        logic [MS_W-1:0]  win_start_ms;
        logic [PCT_W-1:0] percent;
        reading_t         reading_q[$];
        int               errors;
        int               items;
        int               checked;
        int               closes;

        function new();
            win_ms = WIN_RESET;
            start_us = '0;
            timing = 1'b0;
            busy_us = '0;
            win_start_ms = '0;
            percent = '0;
            errors = 0;
            items = 0;
            checked = 0;
            closes = 0;
        endfunction

        function void set_window(logic [WIN_W-1:0] value);
            if (value < WIN_MIN)
                win_ms = WIN_MIN;
            else if (value > WIN_MAX)
                win_ms = WIN_MAX;
            else
                win_ms = value;
        endfunction

        function void note_event(logic [KIND_W-1:0] kind, logic [US_W-1:0] now_us,
                                 logic [MS_W-1:0] now_ms);
            logic [US_W-1:0]  span;
            logic [US_W:0]    sum;
            logic [MS_W-1:0]  elapsed;
            longint unsigned  ratio;
            reading_t         r;
            r.window_closed = 1'b0;
            items++;
            if (kind == KIND_START)
            begin
                if (!timing)
                begin
                    start_us = now_us;
                    timing = 1'b1;
                end
            end
            else if (kind == KIND_END)
            begin
                if (timing)
                begin
                    span = now_us - start_us;
                    sum = {1'b0, busy_us} + {1'b0, span};
                    busy_us = sum[US_W] ? {US_W{1'b1}} : sum[US_W-1:0];
                    timing = 1'b0;
                end
            end
            else if (kind == KIND_TICK)
            begin
                if (win_start_ms == '0)
                begin
                    win_start_ms = now_ms;
                end
                else
                begin
                    elapsed = now_ms - win_start_ms;
                    if (elapsed >= MS_W'(win_ms))
                    begin
                        ratio = (longint'(busy_us) * 100) / (longint'(win_ms) * 1000);
                        percent = (ratio > PCT_MAX) ? PCT_MAX : ratio[PCT_W-1:0];
                        busy_us = '0;
                        win_start_ms = now_ms;
                        r.window_closed = 1'b1;
                        closes++;
                    end
                end
            end
            r.cpu_percent = percent;
            reading_q.push_back(r);
        endfunction

        function void check_result(logic [PCT_W-1:0] cpu_percent, logic window_closed);
            reading_t want;
            if (reading_q.size() == 0)
            begin
                $error("unexpected result beat: cpu_percent %0d window_closed %0d",
                       cpu_percent, window_closed);
                errors++;
                return;
            end
            want = reading_q.pop_front();
            checked++;
            if (cpu_percent !== want.cpu_percent)
            begin
                $error("cpu_percent expected %0d actual %0d", want.cpu_percent, cpu_percent);
                errors++;
            end
            if (window_closed !== want.window_closed)
            begin
                $error("window_closed expected %0d actual %0d",
                       want.window_closed, window_closed);
                errors++;
            end
        endfunction

        function int pending();
            return reading_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [WIN_W-1:0] cfg_wr_data;

    btu_item_if   item_ch ();
    btu_result_if result_ch ();

    busy_time_utilization_monitor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    utilization_scoreboard sb = new();

    int              send_idle_pct;
    int              recv_stall_pct;
    int              cycle_count;
    int              cfg_writes;
    longint unsigned sim_us;
    logic [MS_W-1:0] ms_base;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[busy_time_utilization_monitor] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (recv_stall_pct == 0)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.cpu_percent, result_ch.window_closed);
    end

    function automatic logic [US_W-1:0] cur_us();
        return sim_us[US_W-1:0];
    endfunction

    function automatic logic [MS_W-1:0] cur_ms();
        return ms_base + MS_W'(sim_us / 1000);
    endfunction

    function automatic logic [MS_W-1:0] rand_ms();
        return MS_W'({$urandom, $urandom});
    endfunction

    task automatic send_item(logic [KIND_W-1:0] kind, logic [US_W-1:0] now_us,
                             logic [MS_W-1:0] now_ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.kind   <= kind;
        item_ch.now_us <= now_us;
        item_ch.now_ms <= now_ms;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_event(kind, now_us, now_ms);
    endtask

    // drop valid, hold until every result beat is back, then let the block settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_window(value);
        cfg_writes++;
    endtask

    task automatic set_pressure(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 64;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 64;
            end
            default:
            begin
                send_idle_pct = 17;
                recv_stall_pct = 17;
            end
        endcase
    endtask

    task automatic run_directed();
        send_item(KIND_END, 32'd77, 48'd0);
        send_item(KIND_TICK, 32'd0, 48'd0);
        send_item(KIND_TICK, 32'd0, 48'd0);
        send_item(KIND_TICK, 32'd0, 48'd5);
        send_item(KIND_START, 32'd100, 48'd5);
        send_item(KIND_START, 32'd200, 48'd5);
        send_item(KIND_END, 32'd50100, 48'd55);
        send_item(KIND_TICK, 32'd0, 48'd1004);
        send_item(KIND_TICK, 32'd0, 48'd1005);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_UNUSED, 32'd0, 48'd0);
        send_item(KIND_START, 32'hFFFF_FFF0, 48'd1006);
        send_item(KIND_END, 32'h0000_0010, 48'd1007);
        send_item(KIND_START, 32'd1, 48'd1008);
        send_item(KIND_END, 32'd0, 48'd1009);
        send_item(KIND_START, 32'd0, 48'd1010);
        send_item(KIND_END, 32'hFFFF_FFFF, 48'd1011);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_TICK, 32'd0, 48'd2000);
        send_item(KIND_TICK, 32'd0, 48'd1500);
        send_item(KIND_END, 32'd5, 48'd1500);
    endtask

    task automatic run_segment(int n);
        int unsigned win_us;
        int unsigned dur_max;
        int unsigned gap_max;
        int unsigned tick_max;
        int          r;
        bit          running;
        win_us   = int'(sb.win_ms) * 1000;
        dur_max  = win_us / $urandom_range(1, 6);
        gap_max  = win_us / $urandom_range(1, 6);
        tick_max = win_us / $urandom_range(2, 8);
        running  = 1'b0;
        if ($urandom_range(1) == 0)
            sim_us = 64'hFFFF_FFFF - $urandom_range(0, 3 * win_us);
        else
            sim_us = $urandom;
        ms_base = rand_ms();
        if (ms_base == '0)
            ms_base = 48'd1;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                send_item(KIND_W'($urandom_range(0, 3)), $urandom,
                          ($urandom_range(9) == 0) ? 48'd0 : rand_ms());
            end
            else if (r < 15)
            begin
                send_item(running ? KIND_START : KIND_END, cur_us(), cur_ms());
                sim_us += $urandom_range(0, gap_max);
            end
            else if (r < 72)
            begin
                if (!running)
                begin
                    send_item(KIND_START, cur_us(), cur_ms());
                    sim_us += $urandom_range(0, dur_max);
                end
                else
                begin
                    send_item(KIND_END, cur_us(), cur_ms());
                    sim_us += $urandom_range(0, gap_max);
                end
                running = !running;
            end
            else
            begin
                send_item(KIND_TICK, cur_us(), cur_ms());
                sim_us += $urandom_range(0, tick_max);
            end
        end
    endtask

    initial
    begin
        logic [WIN_W-1:0] win_plan[SEGMENTS];
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_START;
        item_ch.now_us    = '0;
        item_ch.now_ms    = '0;
        result_ch.ready   = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cycle_count       = 0;
        cfg_writes        = 0;
        sim_us            = 0;
        ms_base           = 48'd1;

        win_plan[0] = 11'd0;
        win_plan[1] = 11'd2047;
        win_plan[2] = 11'd100;
        win_plan[3] = 11'd2000;
        win_plan[4] = 11'd99;
        win_plan[5] = 11'd2001;
        win_plan[6] = WIN_W'($urandom_range(0, 2047));
        win_plan[7] = WIN_W'($urandom_range(WIN_MIN, WIN_MAX));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pressure(0);
        run_directed();
        drain();
        set_pressure(3);
        run_directed();
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_window(win_plan[seg]);
            set_pressure(seg % 4);
            run_segment(SEGMENT_ITEMS);
            drain();
        end

        if (sb.pending() != 0)
        begin
            $error("%0d result beats never arrived", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d item beats, %0d result beats checked, %0d windows closed,",
                 sb.items, sb.checked, sb.closes);
        $display("%0d window writes across clamp limits and four idle/stall mixes.",
                 cfg_writes);
        if (sb.errors == 0)
            $display("[busy_time_utilization_monitor] OK");
        else
            $display("[busy_time_utilization_monitor] ERROR");
        $finish;
    end

endmodule
